[sv/ttcg_pkg.sv]
package ttcg_pkg;

  // Field widths of the channels and the configuration port
  localparam int X_W        = 9;
  localparam int Y_W        = 8;
  localparam int COORD_W    = 8;
  localparam int ADDR_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int RAD_W      = 10;
  localparam int SHIFT_W    = 8;

  // Square root datapath: V = 4*ax^2 + k'*ay^2, root = isqrt(V * 2^30)
  localparam int V_W      = 20;
  localparam int ROOT_W   = 25;
  localparam int SQ_REM_W = 26;

  // Divider datapath: ceil(r*s*2^16 / (4*root))
  localparam int DEN_W      = ROOT_W + 2;
  localparam int NUM_W      = 37;
  localparam int DIV_STEPS  = 20;
  localparam int PROD_W     = 2 * RAD_W;

  // CORDIC datapath, angles in Q16 units of 1/256 turn
  localparam int XY_W         = 27;
  localparam int Z_W          = 24;
  localparam int CORDIC_STEPS = 16;

  // Pipeline stage numbers
  localparam int DIV_SETUP = ROOT_W + 1;
  localparam int Q_STAGE   = DIV_SETUP + DIV_STEPS;
  localparam int ANG_STAGE = CORDIC_STEPS + 1;
  localparam int OUT_STAGE = Q_STAGE + 1;

  // Angle constants in Q16 units of 1/256 turn
  localparam logic signed [XY_W-1:0] ANG_ONE     = XY_W'(65536);
  localparam logic signed [XY_W-1:0] ANG_QUARTER = XY_W'(64 * 65536);
  localparam logic signed [XY_W-1:0] ANG_HALF    = XY_W'(128 * 65536);

  localparam logic signed [Z_W-1:0] ATAN_TABLE [0:CORDIC_STEPS-1] = '{
    24'sd2097152, 24'sd1238021, 24'sd654136, 24'sd332050,
    24'sd166669,  24'sd83416,   24'sd41718,  24'sd20860,
    24'sd10430,   24'sd5215,    24'sd2608,   24'sd1304,
    24'sd652,     24'sd326,     24'sd163,    24'sd81
  };

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 3'd0,
    CFG_VIEWER   = 3'd1,
    CFG_ASPECT   = 3'd2,
    CFG_DSHIFT   = 3'd3,
    CFG_ASHIFT   = 3'd4
  } cfg_idx_t;

  // Signs and zero marks of the pixel coordinates
  typedef struct packed {
    logic xn;
    logic yn;
    logic xz;
    logic yz;
  } quad_t;

  // Arithmetic right shift that rounds toward zero
  function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                    input logic [4:0] s);
    logic signed [XY_W-1:0] m;
    m = -v;
    if (v < 0) begin
      return -(m >>> s);
    end
    return v >>> s;
  endfunction

endpackage

[sv/ttcg_if.sv]
// Pixel coordinate channel
interface ttcg_pixel_if;
  import ttcg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] pixel_x;
  logic signed [Y_W-1:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

// Texture coordinate channel
interface ttcg_texel_if;
  import ttcg_pkg::*;
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  depth_coord;
  logic [COORD_W-1:0]  angle_coord;
  logic [ADDR_W-1:0]   texel_address;
  modport source (output valid, depth_coord, angle_coord, texel_address, input ready);
  modport sink   (input valid, depth_coord, angle_coord, texel_address, output ready);
endinterface

[sv/tunnel_texture_coordinate_generator.sv]
// Tunnel texture coordinate generator.
// Pixel beats (signed offsets from the screen centre) enter on the pixel
// channel; each gives one beat on the texel channel with the depth and angle
// coordinates and the texel address angle*256+depth.
// The block is a row of cells: 25 square root cells, then 20 divider cells
// for the depth, with 16 CORDIC cells working alongside for the angle.
// A result leaves the output register after the input stage, the square root
// row, the divider setup and the divider row; one beat is taken every cycle
// while the row is not held.
// The whole row advances together. When a finished result waits in the
// output register and the receiver is not ready, the row holds and the pixel
// channel drops ready; it rises again in the cycle that the result is taken.
// Reset clears the valid marks of every stage and sets the registers to
// radius 200, viewer distance 200, aspect weight 40 and zero shifts.
// Registers are written over the plain write port and should only change
// while no beat is in flight.
module tunnel_texture_coordinate_generator (
  input  logic                               clk,
  input  logic                               rst,
  ttcg_pixel_if.sink                         pixel,
  ttcg_texel_if.source                       texel,
  input  logic                               cfg_wr_en,
  input  logic [ttcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ttcg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ttcg_pkg::*;

  // Configuration registers
  logic [RAD_W-1:0]   radius;
  logic [RAD_W-1:0]   viewer;
  logic               aspect;
  logic [SHIFT_W-1:0] dshift;
  logic [SHIFT_W-1:0] ashift;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RAD_W'(200);
      viewer <= RAD_W'(200);
      aspect <= 1'b0;
      dshift <= '0;
      ashift <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RADIUS: radius <= cfg_data[RAD_W-1:0];
        CFG_VIEWER: viewer <= cfg_data[RAD_W-1:0];
        CFG_ASPECT: aspect <= cfg_data[0];
        CFG_DSHIFT: dshift <= cfg_data[SHIFT_W-1:0];
        CFG_ASHIFT: ashift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid marks and the common advance
  logic [OUT_STAGE:0] vld;
  logic               en;

  assign en          = !vld[OUT_STAGE] || texel.ready;
  assign pixel.ready = en;
  assign texel.valid = vld[OUT_STAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[OUT_STAGE-1:0], pixel.valid};
    end
  end

  // Input stage: magnitudes, weighted squared distance, CORDIC start
  logic [X_W-1:0]    ax;
  logic [Y_W-1:0]    ay;
  logic [16:0]       ax_sq;
  logic [14:0]       ay_sq;
  logic [V_W-1:0]    v_calc;
  quad_t             quad_calc;

  always_comb begin
    ax        = pixel.pixel_x[X_W-1] ? X_W'(-pixel.pixel_x) : pixel.pixel_x;
    ay        = pixel.pixel_y[Y_W-1] ? Y_W'(-pixel.pixel_y) : pixel.pixel_y;
    ax_sq     = 17'({8'b0, ax} * {8'b0, ax});
    ay_sq     = 15'({7'b0, ay} * {7'b0, ay});
    v_calc    = V_W'({ax_sq, 2'b00}) +
                V_W'(V_W'(ay_sq) * (aspect ? V_W'(5) : V_W'(40)));
    quad_calc.xn = pixel.pixel_x[X_W-1];
    quad_calc.yn = pixel.pixel_y[Y_W-1];
    quad_calc.xz = (pixel.pixel_x == '0);
    quad_calc.yz = (pixel.pixel_y == '0);
  end

  logic [SQ_REM_W-1:0]    sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]      sq_root [0:ROOT_W];
  logic [V_W-1:0]         sq_v    [0:ROOT_W];
  logic signed [XY_W-1:0] cx      [0:CORDIC_STEPS];
  logic signed [XY_W-1:0] cy      [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]  cz      [0:CORDIC_STEPS];
  quad_t                  quad    [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_v[0]    <= v_calc;
      cx[0]      <= $signed(XY_W'({ax, 16'h0000}));
      cy[0]      <= $signed(XY_W'({ay, 16'h0000}));
      cz[0]      <= '0;
      quad[0]    <= quad_calc;
    end
  end

  // Square root row: one root bit per cell
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [1:0] pair;
    if (k < V_W / 2) begin : g_data
      assign pair = sq_v[k][V_W-1-2*k -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end
    ttcg_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .pair     (pair),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .v_in     (sq_v[k]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .v_out    (sq_v[k+1])
    );
  end

  // CORDIC row alongside, one rotation per cell
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    ttcg_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .shift (4'(i)),
      .atan  (ATAN_TABLE[i]),
      .x_in  (cx[i]),
      .y_in  (cy[i]),
      .z_in  (cz[i]),
      .x_out (cx[i+1]),
      .y_out (cy[i+1]),
      .z_out (cz[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        quad[i+1] <= quad[i];
      end
    end
  end

  // Angle stage: clamp, axis cases, sign and quadrant corrections
  logic signed [XY_W-1:0] z_ext;
  logic signed [XY_W-1:0] z_cl;
  logic signed [XY_W-1:0] a_mag;
  logic signed [XY_W-1:0] t_sum;
  logic signed [XY_W-1:0] t_int;
  logic                   a_neg;
  logic                   diag;
  quad_t                  qa;
  logic [COORD_W-1:0]     ang [ANG_STAGE:Q_STAGE];

  always_comb begin
    qa    = quad[CORDIC_STEPS];
    z_ext = XY_W'(cz[CORDIC_STEPS]);
    if (z_ext < 0) begin
      z_cl = '0;
    end else if (z_ext > ANG_QUARTER) begin
      z_cl = ANG_QUARTER;
    end else begin
      z_cl = z_ext;
    end
    priority if (qa.yz) begin
      a_mag = '0;
    end else if (qa.xz) begin
      a_mag = ANG_QUARTER;
    end else begin
      a_mag = z_cl;
    end
    a_neg = ((qa.xn != qa.yn) && !qa.xz && !qa.yz) || (qa.xz && qa.yn);
    diag  = ((qa.xn || qa.xz) && (qa.yn || qa.yz)) ||
            (!qa.xn && !qa.xz && !qa.yn && !qa.yz);
    t_sum = (a_neg ? -a_mag : a_mag) + (diag ? ANG_ONE : '0) +
            (!qa.xn ? ANG_HALF : '0);
    t_int = shr_tz(t_sum, 5'd16);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang[ANG_STAGE] <= t_int[COORD_W-1:0];
    end
  end

  for (genvar s = ANG_STAGE; s < Q_STAGE; s++) begin : g_ang
    always_ff @(posedge clk) begin
      if (en) begin
        ang[s+1] <= ang[s];
      end
    end
  end

  // Divider setup: numerator r*s*2^16 + den - 1 for the ceiling
  logic [PROD_W-1:0]    prod;
  logic [DEN_W-1:0]     den_calc;
  logic [NUM_W-1:0]     num_calc;
  logic [DEN_W-1:0]     dv_rem  [DIV_SETUP:Q_STAGE];
  logic [DEN_W-1:0]     dv_den  [DIV_SETUP:Q_STAGE];
  logic [DIV_STEPS-1:0] dv_rest [DIV_SETUP:Q_STAGE];
  logic [COORD_W-1:0]   dv_q    [DIV_SETUP:Q_STAGE];
  logic                 nz      [DIV_SETUP:Q_STAGE];

  always_comb begin
    prod     = PROD_W'(radius) * PROD_W'(viewer);
    den_calc = {sq_root[ROOT_W], 2'b00};
    num_calc = NUM_W'({prod, 16'h0000}) + NUM_W'(den_calc) - NUM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem[DIV_SETUP]  <= DEN_W'(num_calc[NUM_W-1:DIV_STEPS]);
      dv_den[DIV_SETUP]  <= den_calc;
      dv_rest[DIV_SETUP] <= num_calc[DIV_STEPS-1:0];
      dv_q[DIV_SETUP]    <= '0;
      nz[DIV_SETUP]      <= (sq_root[ROOT_W] != '0);
    end
  end

  // Divider row: one quotient bit per cell
  for (genvar j = DIV_SETUP; j < Q_STAGE; j++) begin : g_div
    ttcg_div_cell u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (dv_rem[j]),
      .den_in   (dv_den[j]),
      .rest_in  (dv_rest[j]),
      .q_in     (dv_q[j]),
      .rem_out  (dv_rem[j+1]),
      .den_out  (dv_den[j+1]),
      .rest_out (dv_rest[j+1]),
      .q_out    (dv_q[j+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        nz[j+1] <= nz[j];
      end
    end
  end

  // Output register: scroll offsets and texel address
  logic [COORD_W-1:0] depth_sum;
  logic [COORD_W-1:0] angle_sum;

  always_comb begin
    depth_sum = (nz[Q_STAGE] ? dv_q[Q_STAGE] : '0) + dshift;
    angle_sum = ang[Q_STAGE] + ashift;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      texel.depth_coord   <= depth_sum;
      texel.angle_coord   <= angle_sum;
      texel.texel_address <= {angle_sum, depth_sum};
    end
  end

endmodule

[sv/ttcg_sqrt_cell.sv]
module ttcg_sqrt_cell (
  input  logic                           clk,
  input  logic                           en,
  input  logic [1:0]                     pair,
  input  logic [ttcg_pkg::SQ_REM_W-1:0]  rem_in,
  input  logic [ttcg_pkg::ROOT_W-1:0]    root_in,
  input  logic [ttcg_pkg::V_W-1:0]       v_in,
  output logic [ttcg_pkg::SQ_REM_W-1:0]  rem_out,
  output logic [ttcg_pkg::ROOT_W-1:0]    root_out,
  output logic [ttcg_pkg::V_W-1:0]       v_out
);
  import ttcg_pkg::*;

  logic [SQ_REM_W+1:0] cand;
  logic [SQ_REM_W+1:0] trial;
  logic [SQ_REM_W+1:0] diff;
  logic                ge;

  // One root bit: bring down two radicand bits and try the subtraction.
  always_comb begin
    cand  = {rem_in, pair};
    trial = {1'b0, root_in, 2'b01};
    diff  = cand - trial;
    ge    = (cand >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? diff[SQ_REM_W-1:0] : cand[SQ_REM_W-1:0];
      root_out <= {root_in[ROOT_W-2:0], ge};
      v_out    <= v_in;
    end
  end

endmodule

[sv/ttcg_div_cell.sv]
module ttcg_div_cell (
  input  logic                            clk,
  input  logic                            en,
  input  logic [ttcg_pkg::DEN_W-1:0]      rem_in,
  input  logic [ttcg_pkg::DEN_W-1:0]      den_in,
  input  logic [ttcg_pkg::DIV_STEPS-1:0]  rest_in,
  input  logic [ttcg_pkg::COORD_W-1:0]    q_in,
  output logic [ttcg_pkg::DEN_W-1:0]      rem_out,
  output logic [ttcg_pkg::DEN_W-1:0]      den_out,
  output logic [ttcg_pkg::DIV_STEPS-1:0]  rest_out,
  output logic [ttcg_pkg::COORD_W-1:0]    q_out
);
  import ttcg_pkg::*;

  logic [DEN_W:0] cand;
  logic [DEN_W:0] diff;
  logic           ge;

  // One quotient bit of a restoring division.
  always_comb begin
    cand = {rem_in, rest_in[DIV_STEPS-1]};
    diff = cand - {1'b0, den_in};
    ge   = (cand >= {1'b0, den_in});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
      den_out  <= den_in;
      rest_out <= {rest_in[DIV_STEPS-2:0], 1'b0};
      q_out    <= {q_in[COORD_W-2:0], ge};
    end
  end

endmodule

[sv/ttcg_cordic_cell.sv]
module ttcg_cordic_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [3:0]                        shift,
  input  logic signed [ttcg_pkg::Z_W-1:0]   atan,
  input  logic signed [ttcg_pkg::XY_W-1:0]  x_in,
  input  logic signed [ttcg_pkg::XY_W-1:0]  y_in,
  input  logic signed [ttcg_pkg::Z_W-1:0]   z_in,
  output logic signed [ttcg_pkg::XY_W-1:0]  x_out,
  output logic signed [ttcg_pkg::XY_W-1:0]  y_out,
  output logic signed [ttcg_pkg::Z_W-1:0]   z_out
);
  import ttcg_pkg::*;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [XY_W-1:0] x_next;
  logic signed [XY_W-1:0] y_next;
  logic signed [Z_W-1:0]  z_next;

  // One vectoring rotation, driving y toward zero.
  always_comb begin
    dx = shr_tz(y_in, {1'b0, shift});
    dy = shr_tz(x_in, {1'b0, shift});
    if (!y_in[XY_W-1]) begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + atan;
    end else begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - atan;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= x_next;
      y_out <= y_next;
      z_out <= z_next;
    end
  end

endmodule

[test/tunnel_texture_coordinate_generator_test.sv]
`timescale 1ns / 100ps

module tunnel_texture_coordinate_generator_test;
  import ttcg_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 9;
  localparam int LATENCY      = 47;
  localparam int DRAIN_WAIT   = LATENCY + 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 150;
  localparam int LONG_HOLD    = 300;
  localparam int NO_VALUE     = -1;
  // An index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    logic [COORD_W-1:0] depth;
    logic [COORD_W-1:0] angle;
    logic [ADDR_W-1:0]  addr;
  } texel_t;

  typedef struct {
    int x;
    int y;
    int depth;
    int angle;
  } pixel_row_t;

  typedef struct {
    int radius;
    int viewer;
    int aspect;
    int dshift;
    int ashift;
  } setting_t;

  logic clk;
  logic rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ttcg_pixel_if pix ();
  ttcg_texel_if tex ();

  tunnel_texture_coordinate_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pix),
    .texel     (tex),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's registers.
  int unsigned radius_q;
  int unsigned viewer_q;
  int unsigned aspect_q;
  int unsigned dshift_q;
  int unsigned ashift_q;

  texel_t texels_due[$];
  int     mismatches;
  int     texels_seen;
  int     pixels_sent;
  int     send_idle;
  int     recv_idle;
  logic   hold_start;
  int     hold_left;
  longint cycles;

  // Floor of the square root, bit by bit.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint shift_toward_zero(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  // Vectoring CORDIC: |atan(ay/ax)| in Q16 units of 1/256 turn, clamped.
  function automatic longint first_octant_angle(longint ax, longint ay);
    longint cx, cy, z, dx, dy;
    cx = ax * 65536;
    cy = ay * 65536;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = shift_toward_zero(cy, i);
      dy = shift_toward_zero(cx, i);
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += longint'(ATAN_TABLE[i]);
      end else begin
        cx -= dx; cy += dy; z -= longint'(ATAN_TABLE[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > 64 * 65536) z = 64 * 65536;
    return z;
  endfunction

  // Texture coordinates of one pixel under the current register values.
  function automatic texel_t tunnel_texel(logic signed [X_W-1:0] px,
                                          logic signed [Y_W-1:0] py);
    texel_t r;
    longint x, y, a, t;
    longint unsigned ax, ay, kq, d2, dq, num, den, depth;
    x = px;
    y = py;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    kq = aspect_q ? 64'd81920 : 64'd655360;
    d2 = ax * ax * 65536 + ay * ay * kq;
    dq = floor_root(d2 << 16);
    depth = 0;
    if (dq != 0) begin
      num = longint'(radius_q) * viewer_q * 65536;
      den = dq * 4;
      depth = ((num + den - 1) / den) & 255;
    end
    if (y == 0) a = 0;
    else if (x == 0) a = 64 * 65536;
    else a = first_octant_angle(ax, ay);
    if ((x < 0) != (y < 0) && x != 0 && y != 0) a = -a;
    else if (x == 0 && y < 0) a = -a;
    t = a;
    if ((x <= 0 && y <= 0) || (x > 0 && y > 0)) t += 65536;
    if (x >= 0) t += 128 * 65536;
    t = shift_toward_zero(t, 16);
    r.depth = COORD_W'(depth + dshift_q);
    r.angle = COORD_W'(longint'(t) + ashift_q);
    r.addr  = {r.angle, r.depth};
    return r;
  endfunction

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  // Cycle count and the overall time limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d texels still due", cycles, texels_due.size());
        $display("tunnel_texture_coordinate_generator_test: FAIL");
        $finish;
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each texel beat against the oldest expectation.
  always @(posedge clk) begin
    texel_t want;
    if (rst) begin
      tex.ready <= 1'b0;
    end else begin
      if (tex.valid && tex.ready) begin
        texels_seen++;
        if (texels_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected texel beat: depth %0d angle %0d address %0h",
                     tex.depth_coord, tex.angle_coord, tex.texel_address);
        end else begin
          want = texels_due.pop_front();
          if (tex.depth_coord !== want.depth || tex.angle_coord !== want.angle ||
              tex.texel_address !== want.addr) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Texel mismatch: expected depth %0d angle %0d address %0h, got %0d %0d %0h",
                       want.depth, want.angle, want.addr,
                       tex.depth_coord, tex.angle_coord, tex.texel_address);
          end
        end
      end
      tex.ready <= (hold_left == 0) && !hold_start && ($urandom_range(99) >= recv_idle);
    end
  end

  // Offer one pixel beat and wait for it to be taken. Starts just after an edge.
  task automatic send_pixel(logic signed [X_W-1:0] px, logic signed [Y_W-1:0] py,
                            texel_t want);
    if ($urandom_range(99) < send_idle) begin
      pix.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= px;
    pix.pixel_y <= py;
    do @(posedge clk); while (!pix.ready);
    texels_due.push_back(want);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (texels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    case (idx)
      CFG_RADIUS: radius_q = value & 10'h3ff;
      CFG_VIEWER: viewer_q = value & 10'h3ff;
      CFG_ASPECT: aspect_q = value & 1;
      CFG_DSHIFT: dshift_q = value & 8'hff;
      CFG_ASHIFT: ashift_q = value & 8'hff;
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    write_reg(CFG_RADIUS, s.radius);
    write_reg(CFG_VIEWER, s.viewer);
    write_reg(CFG_ASPECT, s.aspect);
    write_reg(CFG_DSHIFT, s.dshift);
    write_reg(CFG_ASHIFT, s.ashift);
    write_reg(CFG_UNUSED, $urandom_range(1023));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Directed pixels: centre, both axes, corners of the screen and the field.
  pixel_row_t directed_rows [] = '{
    '{0, 0, 0, 129},     '{-1, 0, NO_VALUE, 1},   '{5, 0, NO_VALUE, 128},
    '{255, 0, NO_VALUE, 128}, '{-256, 0, NO_VALUE, 1},
    '{0, 1, NO_VALUE, 192},   '{0, -1, NO_VALUE, 65},
    '{0, 127, NO_VALUE, 192}, '{0, -128, NO_VALUE, 65},
    '{1, 1, NO_VALUE, NO_VALUE},       '{-1, 1, NO_VALUE, NO_VALUE},
    '{1, -1, NO_VALUE, NO_VALUE},      '{-1, -1, NO_VALUE, NO_VALUE},
    '{159, 99, NO_VALUE, NO_VALUE},    '{-160, -100, NO_VALUE, NO_VALUE},
    '{159, -100, NO_VALUE, NO_VALUE},  '{-160, 99, NO_VALUE, NO_VALUE},
    '{255, 127, NO_VALUE, NO_VALUE},   '{-256, -128, NO_VALUE, NO_VALUE},
    '{255, -128, NO_VALUE, NO_VALUE},  '{-256, 127, NO_VALUE, NO_VALUE},
    '{3, 7, NO_VALUE, NO_VALUE},       '{-100, 40, NO_VALUE, NO_VALUE}
  };

  setting_t settings [] = '{
    '{1023, 1023, 1, 255, 255}, '{0, 517, 0, 17, 200}, '{311, 0, 1, 128, 3},
    '{1, 1, 0, 255, 0},         '{640, 380, 1, 90, 77}, '{1023, 1, 0, 0, 255},
    '{200, 200, 0, 0, 0}
  };

  // Main sequence.
  initial begin
    texel_t want;
    logic signed [X_W-1:0] px;
    logic signed [Y_W-1:0] py;
    mismatches  = 0;
    texels_seen = 0;
    pixels_sent = 0;
    send_idle   = 0;
    recv_idle   = 0;
    radius_q = 200; viewer_q = 200; aspect_q = 0; dshift_q = 0; ashift_q = 0;
    pix.valid   <= 1'b0;
    pix.pixel_x <= '0;
    pix.pixel_y <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= CFG_RADIUS;
    cfg_data    <= '0;
    hold_start  <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed part under the reset register values.
    send_idle = 36;
    recv_idle = 62;
    foreach (directed_rows[i]) begin
      px = X_W'(directed_rows[i].x);
      py = Y_W'(directed_rows[i].y);
      want = tunnel_texel(px, py);
      if (directed_rows[i].depth != NO_VALUE) want.depth = COORD_W'(directed_rows[i].depth);
      if (directed_rows[i].angle != NO_VALUE) want.angle = COORD_W'(directed_rows[i].angle);
      want.addr = {want.angle, want.depth};
      send_pixel(px, py, want);
    end
    wait_drained();

    // Random part, one register setting per phase.
    foreach (settings[p]) begin
      if (p == 6) settings[p] = '{$urandom_range(1023), $urandom_range(1023),
                                  $urandom_range(1), $urandom_range(255), $urandom_range(255)};
      apply_setting(settings[p]);
      if (p < 2) begin
        send_idle = 36; recv_idle = 62;
      end else if (p < 4) begin
        send_idle = 62; recv_idle = 36;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // The receiver stops for a long stretch while pixels keep coming.
        if (p == 4 && n == 10) begin
          pix.valid  <= 1'b0;
          hold_start <= 1'b1;
          @(posedge clk);
          hold_start <= 1'b0;
        end
        // The sender stops until every texel is back.
        if (p == 5 && n == PHASE_ITEMS / 2) begin
          pix.valid <= 1'b0;
          @(posedge clk);
          while (texels_due.size() != 0) @(posedge clk);
        end
        if ($urandom_range(99) < 80) begin
          px = X_W'(int'($urandom_range(319)) - 160);
          py = Y_W'(int'($urandom_range(199)) - 100);
        end else begin
          px = X_W'($urandom_range(511));
          py = Y_W'($urandom_range(255));
        end
        send_pixel(px, py, tunnel_texel(px, py));
      end
      wait_drained();
    end

    $display("Sent %0d pixels over %0d register settings and the reset values,",
             pixels_sent, settings.size());
    $display("checked %0d texels with %0d mismatches", texels_seen, mismatches);
    if (mismatches == 0 && texels_due.size() == 0) begin
      $display("tunnel_texture_coordinate_generator_test: PASS");
    end else begin
      $display("tunnel_texture_coordinate_generator_test: FAIL");
    end
    $finish;
  end

endmodule
